// File: hdl/gn3_pkg.sv
// Shared types and constants of the gradient noise block.
`timescale 1ns / 1ps
package gn3_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PERM_W      = 8;
  localparam int COORD_W     = 32;
  localparam int OUT_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 16;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
  localparam int COMP_W      = FRAC_BITS + 2;
  localparam int GRAD_W      = FRAC_BITS + 3;
  localparam int DIFF_W      = FRAC_BITS + 4;
  localparam int FADE_W      = FRAC_BITS + 2;
  localparam int Q_W         = FRAC_BITS + 5;
  localparam int P_W         = DIFF_W + FADE_W + 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [7:0]           tidx;
    logic [PERM_W-1:0]    tval;
    logic [IDX_W-1:0]     cx;
    logic [IDX_W-1:0]     cy;
    logic [IDX_W-1:0]     cz;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [FRAC_BITS-1:0] fz;
  } gn3_item_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] resv;
    logic [OUT_CNT_W-1:0] stored;
    logic                 eval_issue;
  } gn3_status_t;

endpackage

// File: hdl/gradient_noise_3d.sv
// Top level of the three-dimensional gradient noise block.
`timescale 1ns / 1ps
// Usage:
// The input side is a queue: drive a request and raise in_push; it is taken at
// a rising edge where in_full is low. A load request (operation 0) writes one
// permutation table entry and gives no result. A noise request (operation 1)
// carries x, y and z in signed Q15.16 and gives one noise_value in Q0.16.
// All table entries must be loaded before the first noise request.
// The result side is a queue too: while out_empty is low, the oldest result
// is on out_noise_value, and it is taken at a rising edge where out_pop is high.
// An accepted request passes the front register and the decoupling queue,
// then eleven stages of hashing and blending, and its result is then written
// to the result queue before it shows.
// Throughput is one request per cycle while a result slot is free; the hash
// chain reads seven copies of the table, each with two read ports, so every
// level of the hash has its own port. A noise request enters the pipeline only
// with a slot in the 16-entry result queue reserved, so a stalled receiver backs
// up into the decoupling queue and then raises in_full; nothing is lost.
// Loads pass even while results wait. Synchronous reset empties both queues and
// the pipeline; table contents are left as they are and must be loaded again.
module gradient_noise_3d (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_operation,
  input  logic [7:0]                         in_table_index,
  input  logic [7:0]                         in_table_value,
  input  logic signed [gn3_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [gn3_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [gn3_pkg::COORD_W-1:0] in_coord_z,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [gn3_pkg::OUT_W-1:0]          out_noise_value
);

  logic                 f_valid, q_ready, q_valid, q_pop;
  gn3_pkg::gn3_item_t   f_item, q_item;
  gn3_pkg::gn3_status_t st;

  // The front stage registers each request and splits the coordinates.
  gn3_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .f_valid        (f_valid),
    .f_item         (f_item),
    .q_ready        (q_ready)
  );

  // The queue lets the front keep taking requests while the back waits.
  gn3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_item (f_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .head_item (q_item),
    .pop       (q_pop)
  );

  // The back runs freely once a request is issued and owns the result queue.
  gn3_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_noise_value (out_noise_value),
    .status          (st)
  );

`ifndef NO_ASSERTIONS
  // Every stored result was reserved for when its request was issued.
  a_resv_covers: assert property (@(posedge clk) disable iff (!rst_n)
    st.stored <= st.resv) else $error("result queue holds unreserved results");

  // Reset leaves no result showing.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result shown after reset");

  // A taken result frees its reservation.
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !st.eval_issue) |=>
      (st.resv == $past(st.resv) - 1'b1)) else $error("reservation not freed");
`endif

endmodule

// File: hdl/gn3_front.sv
// Input stage: takes requests, splits coordinates into cell and fraction.
`timescale 1ns / 1ps
module gn3_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_operation,
  input  logic [7:0]                    in_table_index,
  input  logic [7:0]                    in_table_value,
  input  logic signed [gn3_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [gn3_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [gn3_pkg::COORD_W-1:0] in_coord_z,
  output logic                          f_valid,
  output gn3_pkg::gn3_item_t            f_item,
  input  logic                          q_ready
);

  logic               vld_r;
  gn3_pkg::gn3_item_t item_r;
  logic               take;
  logic signed [gn3_pkg::COORD_W-1:0] sx, sy, sz;

  assign in_full = vld_r && !q_ready;
  assign take    = in_push && !in_full;

  // Arithmetic shift is the floor of the division by the scale.
  assign sx = in_coord_x >>> gn3_pkg::FRAC_BITS;
  assign sy = in_coord_y >>> gn3_pkg::FRAC_BITS;
  assign sz = in_coord_z >>> gn3_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (q_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.op   <= in_operation;
      item_r.tidx <= in_table_index;
      item_r.tval <= in_table_value;
      item_r.cx   <= sx[gn3_pkg::IDX_W-1:0];
      item_r.cy   <= sy[gn3_pkg::IDX_W-1:0];
      item_r.cz   <= sz[gn3_pkg::IDX_W-1:0];
      item_r.fx   <= in_coord_x[gn3_pkg::FRAC_BITS-1:0];
      item_r.fy   <= in_coord_y[gn3_pkg::FRAC_BITS-1:0];
      item_r.fz   <= in_coord_z[gn3_pkg::FRAC_BITS-1:0];
    end
  end

  assign f_valid = vld_r;
  assign f_item  = item_r;

endmodule

// File: hdl/gn3_queue.sv
// Short queue that decouples the input stage from the evaluation pipeline.
`timescale 1ns / 1ps
module gn3_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gn3_pkg::gn3_item_t push_item,
  output logic               ready,
  output logic               valid,
  output gn3_pkg::gn3_item_t head_item,
  input  logic               pop
);

  localparam int PTR_W = $clog2(gn3_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(gn3_pkg::QUEUE_DEPTH + 1);

  gn3_pkg::gn3_item_t slot_r [gn3_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign ready     = (cnt_r != CNT_W'(gn3_pkg::QUEUE_DEPTH));
  assign valid     = (cnt_r != '0);
  assign head_item = slot_r[rd_r];
  assign do_push   = push && ready;
  assign do_pop    = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_item;
  end

endmodule

// File: hdl/gn3_back.sv
// Evaluation pipeline: table copies, hashing, fade, gradients, blends, result queue.
`timescale 1ns / 1ps
module gn3_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  gn3_pkg::gn3_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [gn3_pkg::OUT_W-1:0]    out_noise_value,
  output gn3_pkg::gn3_status_t         status
);

  localparam int F      = gn3_pkg::FRAC_BITS;
  localparam int IW     = gn3_pkg::IDX_W;
  localparam int NCOPY  = 7;
  localparam int OPTR_W = $clog2(gn3_pkg::OUT_DEPTH);
  localparam int CW     = gn3_pkg::OUT_CNT_W;
  localparam int Q_W_L  = gn3_pkg::Q_W;

  function automatic logic signed [gn3_pkg::GRAD_W-1:0] grad(
    input logic [3:0] h,
    input logic signed [gn3_pkg::COMP_W-1:0] x,
    input logic signed [gn3_pkg::COMP_W-1:0] y,
    input logic signed [gn3_pkg::COMP_W-1:0] z
  );
    logic signed [gn3_pkg::GRAD_W-1:0] u, v;
    u = gn3_pkg::GRAD_W'((h < 4'd8) ? x : y);
    v = gn3_pkg::GRAD_W'((h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z));
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  // Stage control and payload.
  logic               vld_r [4];
  gn3_pkg::gn3_item_t it_r  [4];
  logic               ev_r  [4:10];
  logic               issue, issue_eval;

  // Table copies, two read ports each.
  logic [IW-1:0]              ra0 [NCOPY];
  logic [IW-1:0]              ra1 [NCOPY];
  logic                       we  [NCOPY];
  logic [IW-1:0]              wa  [NCOPY];
  logic [gn3_pkg::PERM_W-1:0] wd  [NCOPY];
  logic [gn3_pkg::PERM_W-1:0] rd0_r [NCOPY];
  logic [gn3_pkg::PERM_W-1:0] rd1_r [NCOPY];

  // Fade pipeline per axis.
  logic [2*F-1:0]            tt_r  [3];
  logic [2*F-1:0]            t3m_r [3];
  logic [F+3:0]              q_r   [3];
  logic [2*F+3:0]            fm_r  [3];
  logic [gn3_pkg::FADE_W-1:0] fade_r [3];
  logic [gn3_pkg::FADE_W-1:0] fv5_r, fv6_r, fw5_r, fw6_r, fw7_r, fw8_r;

  // Blend pipeline.
  logic signed [gn3_pkg::GRAD_W-1:0] grad_r [8];
  logic signed [gn3_pkg::P_W-1:0]    p1_r [4];
  logic signed [gn3_pkg::GRAD_W-1:0] a1_r [4];
  logic signed [gn3_pkg::GRAD_W-1:0] l1_r [4];
  logic signed [gn3_pkg::P_W-1:0]    p2_r [2];
  logic signed [gn3_pkg::GRAD_W-1:0] a2_r [2];
  logic signed [gn3_pkg::GRAD_W-1:0] l2_r [2];
  logic signed [gn3_pkg::P_W-1:0]    p3_r;
  logic signed [gn3_pkg::GRAD_W-1:0] a3_r;
  logic signed [gn3_pkg::GRAD_W-1:0] res_r;

  // Result queue.
  logic [gn3_pkg::OUT_W-1:0] omem [gn3_pkg::OUT_DEPTH];
  logic [OPTR_W-1:0]         owr_r, ord_r;
  logic [CW-1:0]             ocnt_r, resv_r;
  logic                      opop;
  logic [gn3_pkg::OUT_W-1:0] mapped;

  function automatic logic signed [gn3_pkg::GRAD_W-1:0] lerp_end(
    input logic signed [gn3_pkg::GRAD_W-1:0] a,
    input logic signed [gn3_pkg::P_W-1:0] p
  );
    logic signed [gn3_pkg::P_W-1:0] s;
    s = (p >>> F) + gn3_pkg::P_W'(a);
    return $signed(s[gn3_pkg::GRAD_W-1:0]);
  endfunction

  function automatic logic signed [gn3_pkg::P_W-1:0] lerp_mul(
    input logic signed [gn3_pkg::GRAD_W-1:0] a,
    input logic signed [gn3_pkg::GRAD_W-1:0] b,
    input logic [gn3_pkg::FADE_W-1:0] f
  );
    logic signed [gn3_pkg::DIFF_W-1:0] d;
    logic signed [gn3_pkg::FADE_W:0]   fs;
    logic signed [gn3_pkg::P_W-1:0]    p;
    d  = gn3_pkg::DIFF_W'(b) - gn3_pkg::DIFF_W'(a);
    fs = $signed({1'b0, f});
    p  = d * fs;
    return p;
  endfunction

  // Issue: a noise request enters only with a result slot reserved for it.
  assign issue_eval = q_valid && (q_item.op == gn3_pkg::OP_EVAL) &&
                      (resv_r < CW'(gn3_pkg::OUT_DEPTH));
  assign issue      = issue_eval || (q_valid && (q_item.op == gn3_pkg::OP_LOAD));
  assign q_pop      = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) vld_r[i] <= 1'b0;
      for (int i = 4; i <= 10; i++) ev_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= issue;
      for (int i = 1; i < 4; i++) vld_r[i] <= vld_r[i-1];
      ev_r[4] <= vld_r[3] && (it_r[3].op == gn3_pkg::OP_EVAL);
      for (int i = 5; i <= 10; i++) ev_r[i] <= ev_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) it_r[0] <= q_item;
    for (int i = 1; i < 4; i++) it_r[i] <= it_r[i-1];
  end

  // Addresses: each level of the hash reads the copies fed by the level before.
  // A load writes each copy in the stage where that copy is read, so every
  // request sees the table as it stood when it was issued.
  always_comb begin
    logic [IW-1:0] a, b, aa, ab, ba, bb;
    logic          lw [3];
    for (int s = 0; s < 3; s++) begin
      lw[s] = vld_r[s] && (it_r[s].op == gn3_pkg::OP_LOAD) &&
              (32'(it_r[s].tidx) < 32'(gn3_pkg::TABLE_DEPTH));
    end
    a  = IW'(rd0_r[0]) + it_r[1].cy;
    b  = IW'(rd1_r[0]) + it_r[1].cy;
    aa = IW'(rd0_r[1]) + it_r[2].cz;
    ab = IW'(rd1_r[1]) + it_r[2].cz;
    ba = IW'(rd0_r[2]) + it_r[2].cz;
    bb = IW'(rd1_r[2]) + it_r[2].cz;
    ra0[0] = it_r[0].cx; ra1[0] = it_r[0].cx + 1'b1;
    ra0[1] = a;          ra1[1] = a + 1'b1;
    ra0[2] = b;          ra1[2] = b + 1'b1;
    ra0[3] = aa;         ra1[3] = aa + 1'b1;
    ra0[4] = ab;         ra1[4] = ab + 1'b1;
    ra0[5] = ba;         ra1[5] = ba + 1'b1;
    ra0[6] = bb;         ra1[6] = bb + 1'b1;
    for (int c = 0; c < NCOPY; c++) begin
      if (c == 0) begin
        we[c] = lw[0]; wa[c] = IW'(it_r[0].tidx); wd[c] = it_r[0].tval;
      end else if (c < 3) begin
        we[c] = lw[1]; wa[c] = IW'(it_r[1].tidx); wd[c] = it_r[1].tval;
      end else begin
        we[c] = lw[2]; wa[c] = IW'(it_r[2].tidx); wd[c] = it_r[2].tval;
      end
    end
  end

  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    logic [gn3_pkg::PERM_W-1:0] mem [gn3_pkg::TABLE_DEPTH];
    always_ff @(posedge clk) begin
      if (we[c]) mem[wa[c]] <= wd[c];
      rd0_r[c] <= mem[ra0[c]];
      rd1_r[c] <= mem[ra1[c]];
    end
  end

  // Fade 6t^5 - 15t^4 + 10t^3, one multiplier per stage.
  always_ff @(posedge clk) begin
    logic [F-1:0]   t0 [3];
    logic [F-1:0]   t1 [3];
    logic [2*F+2:0] tt6;
    logic [Q_W_L-1:0] pos, neg, qs;
    t0[0] = it_r[0].fx; t0[1] = it_r[0].fy; t0[2] = it_r[0].fz;
    t1[0] = it_r[1].fx; t1[1] = it_r[1].fy; t1[2] = it_r[1].fz;
    for (int k = 0; k < 3; k++) begin
      tt_r[k]  <= (2*F)'(t0[k]) * (2*F)'(t0[k]);
      t3m_r[k] <= (2*F)'(tt_r[k][2*F-1:F]) * (2*F)'(t1[k]);
      tt6 = (2*F+3)'(tt_r[k]) * (2*F+3)'(6);
      pos = Q_W_L'(tt6 >> F) + (Q_W_L'(10) << F);
      neg = Q_W_L'(t1[k]) * Q_W_L'(15);
      qs  = pos - neg;
      q_r[k]  <= qs[Q_W_L-1] ? '0 : qs[F+3:0];
      fm_r[k] <= (2*F+4)'(t3m_r[k][2*F-1:F]) * (2*F+4)'(q_r[k]);
      fade_r[k] <= fm_r[k][F+gn3_pkg::FADE_W-1:F];
    end
  end

  // Gradients, then the three blend levels.
  always_ff @(posedge clk) begin
    logic signed [gn3_pkg::COMP_W-1:0] x0, y0, z0, x1, y1, z1, one;
    one = $signed({2'b01, {F{1'b0}}});
    x0 = $signed({2'b00, it_r[3].fx});
    y0 = $signed({2'b00, it_r[3].fy});
    z0 = $signed({2'b00, it_r[3].fz});
    x1 = x0 - one;
    y1 = y0 - one;
    z1 = z0 - one;
    grad_r[0] <= grad(rd0_r[3][3:0], x0, y0, z0);
    grad_r[1] <= grad(rd0_r[5][3:0], x1, y0, z0);
    grad_r[2] <= grad(rd0_r[4][3:0], x0, y1, z0);
    grad_r[3] <= grad(rd0_r[6][3:0], x1, y1, z0);
    grad_r[4] <= grad(rd1_r[3][3:0], x0, y0, z1);
    grad_r[5] <= grad(rd1_r[5][3:0], x1, y0, z1);
    grad_r[6] <= grad(rd1_r[4][3:0], x0, y1, z1);
    grad_r[7] <= grad(rd1_r[6][3:0], x1, y1, z1);
    for (int i = 0; i < 4; i++) begin
      p1_r[i] <= lerp_mul(grad_r[2*i], grad_r[2*i+1], fade_r[0]);
      a1_r[i] <= grad_r[2*i];
      l1_r[i] <= lerp_end(a1_r[i], p1_r[i]);
    end
    fv5_r <= fade_r[1];
    fv6_r <= fv5_r;
    fw5_r <= fade_r[2];
    fw6_r <= fw5_r;
    fw7_r <= fw6_r;
    fw8_r <= fw7_r;
    for (int j = 0; j < 2; j++) begin
      p2_r[j] <= lerp_mul(l1_r[2*j], l1_r[2*j+1], fv6_r);
      a2_r[j] <= l1_r[2*j];
      l2_r[j] <= lerp_end(a2_r[j], p2_r[j]);
    end
    p3_r  <= lerp_mul(l2_r[0], l2_r[1], fw8_r);
    a3_r  <= l2_r[0];
    res_r <= lerp_end(a3_r, p3_r);
  end

  // (res + 1) / 2 in Q0.16, clamped.
  always_comb begin
    logic signed [gn3_pkg::GRAD_W:0]   n;
    logic [gn3_pkg::GRAD_W+15:0]       sc;
    n  = (gn3_pkg::GRAD_W+1)'(res_r) + $signed({3'b001, {F{1'b0}}});
    sc = {n[gn3_pkg::GRAD_W-1:0], 16'b0} >> (F + 1);
    if (n[gn3_pkg::GRAD_W]) begin
      mapped = '0;
    end else if (sc > (gn3_pkg::GRAD_W+16)'(16'hFFFF)) begin
      mapped = '1;
    end else begin
      mapped = sc[gn3_pkg::OUT_W-1:0];
    end
  end

  assign opop            = out_pop && (ocnt_r != '0);
  assign out_empty       = (ocnt_r == '0);
  assign out_noise_value = omem[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
      resv_r <= '0;
    end else begin
      if (ev_r[10]) owr_r <= owr_r + 1'b1;
      if (opop)     ord_r <= ord_r + 1'b1;
      ocnt_r <= ocnt_r + CW'(ev_r[10]) - CW'(opop);
      resv_r <= resv_r + CW'(issue_eval) - CW'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (ev_r[10]) omem[owr_r] <= mapped;
  end

  assign status.resv       = resv_r;
  assign status.stored     = ocnt_r;
  assign status.eval_issue = issue_eval;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the three-dimensional gradient noise block.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the permutation table, predicts the noise
// value of every accepted noise request and checks the results in order.
class noise_scoreboard;
  bit [7:0]  perm_tbl [256];
  bit [15:0] noise_q [$];
  int        errors;

  function longint fade(longint t);
    longint t2, t3, q;
    t2 = (t * t) >>> gn3_pkg::FRAC_BITS;
    t3 = (t2 * t) >>> gn3_pkg::FRAC_BITS;
    q = ((6 * t * t) >>> gn3_pkg::FRAC_BITS) + 10 * (64'sd1 << gn3_pkg::FRAC_BITS) - 15 * t;
    if (q < 0) q = 0;
    return (t3 * q) >>> gn3_pkg::FRAC_BITS;
  endfunction

  // Arithmetic shift of a signed product rounds toward minus infinity.
  function longint mix(longint f, longint a, longint b);
    return a + (((b - a) * f) >>> gn3_pkg::FRAC_BITS);
  endfunction

  function longint grad(bit [7:0] hash, longint x, longint y, longint z);
    bit [3:0] h;
    longint   u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function bit [7:0] p(bit [7:0] i);
    return perm_tbl[i];
  endfunction

  function void note_request(bit op, bit [7:0] idx, bit [7:0] val,
                             bit [31:0] rx, bit [31:0] ry, bit [31:0] rz);
    longint   s, x, y, z, x1, y1, z1, u, v, w, res, n;
    bit [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    if (op == gn3_pkg::OP_LOAD) begin
      perm_tbl[idx] = val;
      return;
    end
    s = 64'sd1 << gn3_pkg::FRAC_BITS;
    x = rx[15:0];
    y = ry[15:0];
    z = rz[15:0];
    // The cell is the integer part, kept modulo the table depth.
    cx = rx[23:16];
    cy = ry[23:16];
    cz = rz[23:16];
    u = fade(x);
    v = fade(y);
    w = fade(z);
    x1 = x - s;
    y1 = y - s;
    z1 = z - s;
    a  = p(cx) + cy;
    aa = p(a) + cz;
    ab = p(a + 8'd1) + cz;
    b  = p(cx + 8'd1) + cy;
    ba = p(b) + cz;
    bb = p(b + 8'd1) + cz;
    res = mix(w,
      mix(v, mix(u, grad(p(aa), x, y, z), grad(p(ba), x1, y, z)),
             mix(u, grad(p(ab), x, y1, z), grad(p(bb), x1, y1, z))),
      mix(v, mix(u, grad(p(aa + 8'd1), x, y, z1), grad(p(ba + 8'd1), x1, y, z1)),
             mix(u, grad(p(ab + 8'd1), x, y1, z1), grad(p(bb + 8'd1), x1, y1, z1))));
    n = res + s;
    if (n < 0) n = 0;
    n = (n * 65536) >>> (gn3_pkg::FRAC_BITS + 1);
    if (n > 65535) n = 65535;
    noise_q.push_back(n[15:0]);
  endfunction

  function void check_result(bit [15:0] got);
    bit [15:0] want;
    if (noise_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result noise_value=%h", got);
      return;
    end
    want = noise_q.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("noise_value mismatch: expected %h, actual %h", want, got);
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_operation;
  logic [7:0]  in_table_index;
  logic [7:0]  in_table_value;
  logic signed [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_noise_value;

  noise_scoreboard sb;
  int send_idle;   // percent of cycles in which the sender holds back
  int recv_idle;   // percent of cycles in which the receiver refuses
  int quiet_cycles;

  gradient_noise_3d u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_table_index(in_table_index),
    .in_table_value(in_table_value),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_empty(out_empty), .out_pop(out_pop), .out_noise_value(out_noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver pops at random according to its current idle share.
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: inputs and outputs are sampled before this edge's updates land,
  // so every accepted request and result is seen exactly once.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_push && !in_full)
        sb.note_request(in_operation, in_table_index, in_table_value,
                        in_coord_x, in_coord_y, in_coord_z);
      if (out_pop && !out_empty) sb.check_result(out_noise_value);
      // A hang shows up as a long stretch with no request or result moving.
      if (quiet_cycles > 5000) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(bit op, bit [7:0] idx, bit [7:0] val,
                              bit [31:0] x, bit [31:0] y, bit [31:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_operation   <= op;
    in_table_index <= idx;
    in_table_value <= val;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    do @(posedge clk); while (in_full);
  endtask

  task automatic load_entry(bit [7:0] idx, bit [7:0] val);
    send_request(gn3_pkg::OP_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic eval_point(bit [31:0] x, bit [31:0] y, bit [31:0] z);
    send_request(gn3_pkg::OP_EVAL, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  // Coordinates: a third near the origin, a third at fraction or range edges,
  // a third fully random so every bit toggles.
  function automatic bit [31:0] pick_coord();
    bit [31:0] c;
    case ($urandom_range(5))
      0, 1: c = $signed($urandom_range(16 << 16)) - (8 << 16);
      2: c = {$urandom_range(1) ? 16'hFFFF : 16'h0000, $urandom_range(1) ? 16'hFFFF : 16'h0000};
      3: c = {$urandom_range(1) ? 1'b1 : 1'b0, $urandom_range(1) ? 31'h7FFFFFFF : 31'h0};
      default: c = $urandom;
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.noise_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) begin
      // Table rewrites keep every entry defined, so no unwritten read occurs.
      if ($urandom_range(99) < 15) load_entry(8'($urandom), 8'($urandom));
      else eval_point(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    sb = new();
    send_idle = 16;
    recv_idle = 69;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_operation = gn3_pkg::OP_LOAD;
    in_table_index = '0;
    in_table_value = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    out_pop = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An all-ones table drives every corner to the same gradient.
    for (int i = 0; i < 256; i++) load_entry(8'(i), 8'hFF);
    eval_point(32'h0, 32'h0, 32'h0);
    eval_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    // Then a random table for the range and wrap cases.
    for (int i = 0; i < 256; i++) load_entry(8'(i), 8'($urandom));
    eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000);
    eval_point(32'h00FF_FFFF, 32'h00FF_0000, 32'h00FF_8000);
    eval_point(32'h0000_0001, 32'hFFFF_FFFE, 32'h0100_0000);
    eval_point(32'h8000_FFFF, 32'h7FFF_0000, 32'h0000_0000);
    load_entry(8'd0, 8'd0);
    load_entry(8'd255, 8'd255);
    eval_point(32'h00FF_4000, 32'h00FF_C000, 32'h00FF_2000);
    eval_point(32'h0000_4000, 32'h0000_C000, 32'h0000_2000);

    random_phase(475);
    // The sender stops here until every outstanding result has come back.
    wait_drained();
    send_idle = 69;
    recv_idle = 16;
    random_phase(475);
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    random_phase(475);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.noise_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
